// ----- sv/aikm_pkg.sv -----
// Shared types and constants for the agent identity key matcher.
// Holds the parse phase enum, status codes and the result struct.
// No dependencies; imported by the parser and the top level.
package aikm_pkg;

   // Default of the accepted message size
   localparam int MAX_RESPONSE_BYTES_DEF = 65536;

   // Key register geometry
   localparam int KEY_REGS  = 4;
   localparam int KEY_REG_W = 64;
   localparam int KEY_BYTES = 32;
   localparam int KEY_W     = KEY_REGS * KEY_REG_W;

   // Configuration port
   localparam int CSR_ADDR_W = 8;

   // Message layout constants
   localparam logic [7:0]  ANSWER_TYPE   = 8'd12;
   localparam logic [31:0] KEY_LEN       = 32'd32;
   localparam int          MIN_MSG_BYTES = 9;
   localparam int          TYPE_POS      = 4;
   localparam int          COUNT_POS_LO  = 5;
   localparam int          COUNT_POS_HI  = 8;
   localparam logic [31:0] LEN_FIELD     = 32'd4;

   typedef enum logic [3:0] {
      PH_HEADER      = 4'd0,
      PH_BLOBLEN     = 4'd1,
      PH_TYPELEN     = 4'd2,
      PH_SKIPTYPE    = 4'd3,
      PH_KEYLEN      = 4'd4,
      PH_COMPARE     = 4'd5,
      PH_SKIPBLOB    = 4'd6,
      PH_COMMENTLEN  = 4'd7,
      PH_SKIPCOMMENT = 4'd8,
      PH_DONE        = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_BAD_TYPE = 2'd2
   } status_type;

   typedef struct packed {
      logic       found;
      status_type status;
   } result_type;

endpackage

// ----- sv/aikm_parser.sv -----
// Byte-serial parser for an identities-answer message.
// Walks header, key blobs and comments and compares the key string.
// Depends on aikm_pkg.
module aikm_parser #(
   parameter int MAX_RESPONSE_BYTES = aikm_pkg::MAX_RESPONSE_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   input  logic                     last,
   input  logic [aikm_pkg::KEY_W-1:0] key_vec,
   output aikm_pkg::result_type     result
);
   import aikm_pkg::*;

   localparam int POS_W = $clog2(MAX_RESPONSE_BYTES + 1);

   phase_type   phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0] keys_ff, keys_in;
   logic [31:0] field_ff, field_in;
   logic [32:0] blob_ff, blob_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  ci_ff, ci_in;
   logic        cand_ff, cand_in;
   logic        found_ff, found_in;
   status_type  err_ff, err_in;

   logic [7:0]  key_byte;
   logic        in_range;

   // Select the key byte under comparison, byte 0 most significant
   assign key_byte = key_vec[(KEY_BYTES - 1 - int'(ci_ff[4:0])) * 8 +: 8];
   assign in_range = pos_ff < POS_W'(MAX_RESPONSE_BYTES);

   // Next-state logic for one byte
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      keys_in  = keys_ff;
      field_in = field_ff;
      blob_in  = blob_ff;
      acc_in   = acc_ff;
      ci_in    = ci_ff;
      cand_in  = cand_ff;
      found_in = found_ff;
      err_in   = err_ff;
      if (in_range) begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == POS_W'(TYPE_POS)) begin
                  if (data_byte != ANSWER_TYPE) begin
                     err_in   = STATUS_BAD_TYPE;
                     phase_in = PH_DONE;
                  end
               end else if (pos_ff >= POS_W'(COUNT_POS_LO)) begin
                  keys_in = {keys_ff[23:0], data_byte};
                  if (pos_ff == POS_W'(COUNT_POS_HI)) begin
                     if (keys_in == 32'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        keys_in  = keys_in - 32'd1;
                        phase_in = PH_BLOBLEN;
                        field_in = LEN_FIELD;
                        acc_in   = 32'd0;
                     end
                  end
               end
            end
            PH_BLOBLEN: begin
               acc_in   = {acc_ff[23:0], data_byte};
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  blob_in = {1'b0, acc_in};
                  cand_in = 1'b0;
                  if (acc_in == 32'd0) begin
                     phase_in = PH_COMMENTLEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end else if (acc_in < LEN_FIELD) begin
                     phase_in = PH_SKIPBLOB;
                  end else begin
                     phase_in = PH_TYPELEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end
               end
            end
            PH_TYPELEN: begin
               blob_in  = blob_ff - 33'd1;
               acc_in   = {acc_ff[23:0], data_byte};
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  if (({1'b0, acc_in} + 33'd4) > blob_in) begin
                     // type string overruns the blob: skip the rest
                     if (blob_in == 33'd0) begin
                        if (cand_in) found_in = 1'b1;
                        cand_in  = 1'b0;
                        phase_in = PH_COMMENTLEN;
                        field_in = LEN_FIELD;
                        acc_in   = 32'd0;
                     end else begin
                        phase_in = PH_SKIPBLOB;
                     end
                  end else if (acc_in == 32'd0) begin
                     phase_in = PH_KEYLEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end else begin
                     field_in = acc_in;
                     phase_in = PH_SKIPTYPE;
                  end
               end
            end
            PH_SKIPTYPE: begin
               blob_in  = blob_ff - 33'd1;
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  phase_in = PH_KEYLEN;
                  field_in = LEN_FIELD;
                  acc_in   = 32'd0;
               end
            end
            PH_KEYLEN: begin
               blob_in  = blob_ff - 33'd1;
               acc_in   = {acc_ff[23:0], data_byte};
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  if (acc_in == KEY_LEN && blob_in >= {1'b0, KEY_LEN}) begin
                     phase_in = PH_COMPARE;
                     ci_in    = 6'd0;
                     cand_in  = 1'b1;
                  end else if (blob_in == 33'd0) begin
                     if (cand_in) found_in = 1'b1;
                     cand_in  = 1'b0;
                     phase_in = PH_COMMENTLEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end else begin
                     phase_in = PH_SKIPBLOB;
                  end
               end
            end
            PH_COMPARE: begin
               blob_in = blob_ff - 33'd1;
               if (data_byte != key_byte) cand_in = 1'b0;
               ci_in = ci_ff + 6'd1;
               if (ci_in >= 6'(KEY_BYTES)) begin
                  if (blob_in == 33'd0) begin
                     if (cand_in) found_in = 1'b1;
                     cand_in  = 1'b0;
                     phase_in = PH_COMMENTLEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end else begin
                     phase_in = PH_SKIPBLOB;
                  end
               end
            end
            PH_SKIPBLOB: begin
               blob_in = blob_ff - 33'd1;
               if (blob_in == 33'd0) begin
                  if (cand_in) found_in = 1'b1;
                  cand_in  = 1'b0;
                  phase_in = PH_COMMENTLEN;
                  field_in = LEN_FIELD;
                  acc_in   = 32'd0;
               end
            end
            PH_COMMENTLEN: begin
               acc_in   = {acc_ff[23:0], data_byte};
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  if (acc_in == 32'd0) begin
                     // advance to the next key entry
                     if (keys_ff == 32'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        keys_in  = keys_ff - 32'd1;
                        phase_in = PH_BLOBLEN;
                        field_in = LEN_FIELD;
                        acc_in   = 32'd0;
                     end
                  end else begin
                     field_in = acc_in;
                     phase_in = PH_SKIPCOMMENT;
                  end
               end
            end
            PH_SKIPCOMMENT: begin
               field_in = field_ff - 32'd1;
               if (field_in == 32'd0) begin
                  if (keys_ff == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     keys_in  = keys_ff - 32'd1;
                     phase_in = PH_BLOBLEN;
                     field_in = LEN_FIELD;
                     acc_in   = 32'd0;
                  end
               end
            end
            default: begin
               // key count exhausted or bad type: ignore the byte
            end
         endcase
      end
   end

   // Result for the final byte of a message
   always_comb begin
      if (pos_in < POS_W'(MIN_MSG_BYTES)) begin
         result.status = STATUS_SHORT;
      end else begin
         result.status = err_in;
      end
      result.found = (result.status == STATUS_OK) && found_in;
   end

   // Hold parse state; clear it after the final byte
   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         keys_ff  <= '0;
         field_ff <= '0;
         blob_ff  <= '0;
         acc_ff   <= '0;
         ci_ff    <= '0;
         cand_ff  <= 1'b0;
         found_ff <= 1'b0;
         err_ff   <= STATUS_OK;
      end else if (take) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         keys_ff  <= keys_in;
         field_ff <= field_in;
         blob_ff  <= blob_in;
         acc_ff   <= acc_in;
         ci_ff    <= ci_in;
         cand_ff  <= cand_in;
         found_ff <= found_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ----- sv/agent_identity_key_matcher.sv -----
// The result appears on rsp in the cycle after the final byte is transferred.
// Throughput: one byte per cycle while req_tready is high; the parser state updates in the cycle a byte arrives.
// req_tready drops only while a result sits in the output register untaken.
// Reset (synchronous, active high) clears the parser, the output valid flag
// and the four key registers.
module agent_identity_key_matcher #(
   parameter int MAX_RESPONSE_BYTES = aikm_pkg::MAX_RESPONSE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] data_byte
   input  logic                          req_tlast,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // [0] found, [2:1] status, [7:3] zero
   // key register writes
   input  logic                          csr_we,
   input  logic [aikm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [aikm_pkg::KEY_REG_W-1:0]  csr_wdata
);
   import aikm_pkg::*;

   logic [KEY_REG_W-1:0] key_ff [KEY_REGS];
   logic [KEY_W-1:0]     key_vec;
   logic                 take;
   result_type           result;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign key_vec    = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};

   // Write key registers; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REGS; i++) key_ff[i] <= '0;
      end else if (csr_we && (csr_addr < CSR_ADDR_W'(KEY_REGS))) begin
         key_ff[csr_addr[1:0]] <= csr_wdata;
      end
   end

   aikm_parser #(
      .MAX_RESPONSE_BYTES(MAX_RESPONSE_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .last      (req_tlast),
      .key_vec   (key_vec),
      .result    (result)
   );

   // Hold the result until the downstream transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.status, rsp_data_ff.found};

endmodule

// ----- sv/aikm_checker.sv -----
// Port-level checks for agent_identity_key_matcher.
// Sees only the top-level ports; attached by the bind at the end of the file.
// Depends on aikm_pkg for the status codes.
module aikm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import aikm_pkg::*;

   // Stalled result holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Found only with a clean status, status within the known codes, padding zero
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:3] == 5'd0) && (rsp_tdata[2:1] <= STATUS_BAD_TYPE)
                     && !(rsp_tdata[0] && (rsp_tdata[2:1] != STATUS_OK)))
      else $error("bad result encoding");

   // Final byte yields a result next cycle
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("final byte without result");

   // Non-final byte with a free output yields no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("result without final byte");

   // Input stalls only behind a waiting result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");

endmodule

bind agent_identity_key_matcher aikm_checker u_aikm_checker (.*);
